@@ rtl/core/i2d_pkg.sv @@
// Shared constants, types and state encoding for the integer to decimal ASCII converter.
package i2d_pkg;

   // Width of the number taken from each request (8 to 64).
   localparam int VALUE_WIDTH = 64;
   // Fixed width of the request value port.
   localparam int VALUE_PORT_W = 64;
   // Decimal digits needed for VALUE_WIDTH bits: floor(W * log10(2)) + 1.
   localparam int NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
   localparam int DIGIT_W = 4;
   localparam int BCD_W = NUM_DIGITS * DIGIT_W;
   localparam int CNT_W = $clog2(VALUE_WIDTH);
   localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS + 1);
   localparam int CHAR_W = 5;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [DIGIT_W-1:0] ADJUST_MIN = 4'd5;
   localparam logic [DIGIT_W-1:0] ADJUST_ADD = 4'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_TRIM,
      ST_EMIT
   } i2d_state_type;

   // Controls from the sequencer to the shift/add-3 unit.
   typedef struct packed {
      logic load;
      logic convert;
      logic shift_digit;
   } i2d_ctrl_type;

endpackage

@@ rtl/core/int64_to_decimal_ascii.sv @@
// Integer to decimal ASCII converter top level: sequencer and handshakes.
// Converts one number at a time, signed (req_func = 0) or unsigned (req_func = 1), into its
// decimal text, most significant character first, with a leading '-' for negative signed
// values and no leading zeros. An accepted item first runs through the shared shift/add-3
// unit, then through leading-zero trimming, then out at one character per cycle while the
// sink takes each at once, with output stalls holding it back.
// req_ready is low from acceptance until the last character is transferred.
module int64_to_decimal_ascii (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic [i2d_pkg::VALUE_PORT_W-1:0]    req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_character,
   output logic                                rsp_last_char,
   output logic [i2d_pkg::CHAR_W-1:0]          rsp_total_chars
);
   import i2d_pkg::*;

   i2d_state_type           state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [DIGIT_CNT_W-1:0]  ndig_ff, ndig_in;
   logic                    neg_ff, neg_in;
   logic                    sign_pend_ff, sign_pend_in;
   logic [CHAR_W-1:0]       remain_ff, remain_in;
   logic [CHAR_W-1:0]       total_ff, total_in;
   i2d_ctrl_type            ctrl;
   logic [DIGIT_W-1:0]      top_digit;
   logic                    req_xfer;
   logic                    rsp_xfer;
   logic                    req_neg;
   logic                    can_trim;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;
   assign req_neg  = !req_func && req_value[VALUE_WIDTH-1];
   assign can_trim = (top_digit == '0) && (ndig_ff > DIGIT_CNT_W'(1));

   i2d_dabble u_dabble (
      .clock      (clock),
      .ctrl       (ctrl),
      .negate     (req_neg),
      .load_value (req_value[VALUE_WIDTH-1:0]),
      .top_digit  (top_digit)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (cnt_ff == '0) state_in = ST_TRIM;
         end
         ST_TRIM: begin
            if (!can_trim) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_xfer && remain_ff == CHAR_W'(1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshakes and unit controls.
   always_comb begin
      req_ready        = 1'b0;
      rsp_valid        = 1'b0;
      ctrl             = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = req_valid;
         end
         ST_CONVERT: ctrl.convert = 1'b1;
         ST_TRIM:    ctrl.shift_digit = can_trim;
         ST_EMIT: begin
            rsp_valid        = 1'b1;
            ctrl.shift_digit = rsp_ready && !sign_pend_ff;
         end
         default: ;
      endcase
   end

   // Counters and per-number flags.
   always_comb begin
      cnt_in       = cnt_ff;
      ndig_in      = ndig_ff;
      neg_in       = neg_ff;
      sign_pend_in = sign_pend_ff;
      remain_in    = remain_ff;
      total_in     = total_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cnt_in  = CNT_W'(VALUE_WIDTH - 1);
               ndig_in = DIGIT_CNT_W'(NUM_DIGITS);
               neg_in  = req_neg;
            end
         end
         ST_CONVERT: cnt_in = cnt_ff - CNT_W'(1);
         ST_TRIM: begin
            if (can_trim) begin
               ndig_in = ndig_ff - DIGIT_CNT_W'(1);
            end else begin
               total_in     = CHAR_W'(ndig_ff) + CHAR_W'(neg_ff);
               remain_in    = CHAR_W'(ndig_ff) + CHAR_W'(neg_ff);
               sign_pend_in = neg_ff;
            end
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               remain_in    = remain_ff - CHAR_W'(1);
               sign_pend_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // Hold control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sign_pend_ff <= 1'b0;
         remain_ff    <= '0;
         cnt_ff       <= '0;
         ndig_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         sign_pend_ff <= sign_pend_in;
         remain_ff    <= remain_in;
         cnt_ff       <= cnt_in;
         ndig_ff      <= ndig_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      total_ff <= total_in;
   end

   // Present the current character.
   assign rsp_character   = sign_pend_ff ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, top_digit});
   assign rsp_last_char   = (remain_ff == CHAR_W'(1));
   assign rsp_total_chars = total_ff;

endmodule

@@ rtl/core/i2d_dabble.sv @@
// Shared shift/add-3 unit: binary magnitude register and BCD digit register.
module i2d_dabble (
   input  logic                                     clock,
   input  i2d_pkg::i2d_ctrl_type                    ctrl,
   input  logic                                     negate,
   input  logic [i2d_pkg::VALUE_WIDTH-1:0]          load_value,
   output logic [i2d_pkg::DIGIT_W-1:0]              top_digit
);
   import i2d_pkg::*;

   logic [VALUE_WIDTH-1:0] mag_ff;
   logic [VALUE_WIDTH-1:0] mag_in;
   logic [BCD_W-1:0]       bcd_ff;
   logic [BCD_W-1:0]       bcd_in;
   logic [BCD_W-1:0]       bcd_adj;

   // Add 3 to every digit of five or more before the next shift.
   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d*DIGIT_W +: DIGIT_W] >= ADJUST_MIN) begin
            bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_ff[d*DIGIT_W +: DIGIT_W] + ADJUST_ADD;
         end else begin
            bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_ff[d*DIGIT_W +: DIGIT_W];
         end
      end
   end

   // Load the magnitude, step the conversion, or drop the top digit.
   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      priority if (ctrl.load) begin
         mag_in = negate ? (~load_value + VALUE_WIDTH'(1)) : load_value;
         bcd_in = '0;
      end else if (ctrl.convert) begin
         mag_in = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_WIDTH-1]};
      end else if (ctrl.shift_digit) begin
         bcd_in = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      end else begin
         mag_in = mag_ff;
         bcd_in = bcd_ff;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_W-1 -: DIGIT_W];

endmodule

@@ rtl/core/i2d_checker.sv @@
// Port-level checker for the integer to decimal ASCII converter, bound to the top level.
module i2d_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [7:0]                       rsp_character,
   input logic                             rsp_last_char,
   input logic [i2d_pkg::CHAR_W-1:0]       rsp_total_chars
);
   import i2d_pkg::*;

   // A stalled character holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character)
         && $stable(rsp_last_char) && $stable(rsp_total_chars))
      else $error("stalled character changed");

   // Conversion takes time: no character and no new request right after a transfer in.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid && !req_ready)
      else $error("output or ready right after request transfer");

   // Never accept while text is pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("ready while emitting");

   // Text continues after a non-final character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_char |=> rsp_valid && !req_ready
         && rsp_total_chars == $past(rsp_total_chars))
      else $error("text ended early or length changed");

   // Character count stays in range and a character is a digit or minus.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_total_chars != '0 && rsp_total_chars <= CHAR_W'(20)
         && (rsp_character == CHAR_MINUS
             || (rsp_character >= CHAR_ZERO && rsp_character <= CHAR_ZERO + 8'd9)))
      else $error("bad character or length");

endmodule

bind int64_to_decimal_ascii i2d_checker u_i2d_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_character   (rsp_character),
   .rsp_last_char   (rsp_last_char),
   .rsp_total_chars (rsp_total_chars)
);

@@ dv/int64_to_decimal_ascii_tb.sv @@
// Self-checking testbench for the integer to decimal ASCII converter.
module int64_to_decimal_ascii_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i2d_pkg::*;

   localparam logic FUNC_SIGNED   = 1'b0;
   localparam logic FUNC_UNSIGNED = 1'b1;
   localparam int   MAX_TEXT_CHARS = 20;
   localparam int   LONG_HOLD_CYCLES = 600;
   localparam int   DRAIN_LIMIT = 20000;
   localparam int   TAIL_CYCLES = 120;

   typedef struct packed {
      logic [7:0]        character;
      logic              last_char;
      logic [CHAR_W-1:0] total_chars;
   } ascii_char_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_func;
   logic [VALUE_PORT_W-1:0] req_value;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [7:0]              rsp_character;
   logic                    rsp_last_char;
   logic [CHAR_W-1:0]       rsp_total_chars;

   // Characters still owed by the block, oldest first.
   ascii_char_type pending_chars[$];
   int mismatch_count = 0;

   // Sender pacing: bursts of items separated by idle gaps.
   int burst_left = 0;
   int gap_max = 0;
   int burst_max = 1;

   // Receiver pacing: random stall episodes plus a requested long hold-off.
   int stall_pct = 0;
   int stall_max = 0;
   int stall_left = 0;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;

   int64_to_decimal_ascii u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_character   (rsp_character),
      .rsp_last_char   (rsp_last_char),
      .rsp_total_chars (rsp_total_chars)
   );

   // Free-running clock, 8 ns period.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Work out the decimal text of one number and queue its characters.
   function automatic void append_decimal_text(input logic func,
                                               input logic [VALUE_PORT_W-1:0] value);
      logic [63:0] mask;
      logic [63:0] bits;
      logic [63:0] mag;
      logic [7:0]  rev [MAX_TEXT_CHARS];
      logic [7:0]  text [MAX_TEXT_CHARS];
      logic        negative;
      int          num_digits;
      int          total;
      ascii_char_type item;
      mask = (VALUE_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_WIDTH) - 64'd1);
      bits = value & mask;
      negative = (func == FUNC_SIGNED) && bits[VALUE_WIDTH-1];
      // Two's complement magnitude stays exact for the most negative value.
      mag = negative ? ((~bits + 64'd1) & mask) : bits;
      num_digits = 0;
      total = 0;
      do begin
         if (num_digits < MAX_TEXT_CHARS) begin
            rev[num_digits] = CHAR_ZERO + 8'(mag % 64'd10);
            num_digits++;
         end
         mag = mag / 64'd10;
      end while (mag != 64'd0);
      if (negative) begin
         text[total] = CHAR_MINUS;
         total++;
      end
      for (int k = 0; k < num_digits && total < MAX_TEXT_CHARS; k++) begin
         text[total] = rev[num_digits - 1 - k];
         total++;
      end
      for (int k = 0; k < total; k++) begin
         item.character   = text[k];
         item.last_char   = (k + 1 == total);
         item.total_chars = CHAR_W'(total);
         pending_chars.push_back(item);
      end
   endfunction

   // Offer one number and hold it until the transfer, then predict its text.
   task automatic send_number(input logic func, input logic [VALUE_PORT_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, burst_max);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_func  <= func;
      req_value <= value;
      do @(posedge clock); while (req_ready !== 1'b1);
      append_decimal_text(func, value);
   endtask

   // Extremes, both interpretations, digit-count boundaries.
   task automatic test_directed_values();
      gap_max   = 3;
      burst_max = 2;
      stall_pct <= 0;
      stall_max <= 0;
      send_number(FUNC_SIGNED,   64'd0);
      send_number(FUNC_UNSIGNED, 64'd0);
      send_number(FUNC_SIGNED,   64'd1);
      send_number(FUNC_SIGNED,   64'hFFFF_FFFF_FFFF_FFFF);
      send_number(FUNC_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
      send_number(FUNC_SIGNED,   64'h8000_0000_0000_0000);
      send_number(FUNC_UNSIGNED, 64'h8000_0000_0000_0000);
      send_number(FUNC_SIGNED,   64'h7FFF_FFFF_FFFF_FFFF);
      send_number(FUNC_UNSIGNED, 64'h7FFF_FFFF_FFFF_FFFF);
      send_number(FUNC_UNSIGNED, 64'h8000_0000_0000_0001);
      send_number(FUNC_SIGNED,   64'd9);
      send_number(FUNC_SIGNED,   64'd10);
      send_number(FUNC_UNSIGNED, 64'd99);
      send_number(FUNC_UNSIGNED, 64'd100);
      send_number(FUNC_SIGNED,   -64'd9);
      send_number(FUNC_SIGNED,   -64'd10);
      send_number(FUNC_UNSIGNED, 64'd10000000000000000000);
      send_number(FUNC_UNSIGNED, 64'd9999999999999999999);
      send_number(FUNC_SIGNED,   64'd1000000000000000000);
      send_number(FUNC_SIGNED,   -64'd1000000000000000000);
      send_number(FUNC_SIGNED,   64'hA5A5_0000_0000_007B);
      send_number(FUNC_UNSIGNED, 64'h5A5A_FFFF_FFFF_FF84);
   endtask

   // Random numbers of every length, pacing changed every few dozen items.
   task automatic test_random_numbers(input int count);
      logic [63:0] value;
      logic [63:0] power;
      logic        func;
      int          exponent;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) begin
            case ((i / 50) % 3)
               0: begin
                  gap_max   = 0;
                  burst_max = 8;
                  stall_pct <= 0;
                  stall_max <= 0;
               end
               1: begin
                  gap_max   = 40;
                  burst_max = 3;
                  stall_pct <= 15;
                  stall_max <= 3;
               end
               default: begin
                  gap_max   = 150;
                  burst_max = 2;
                  stall_pct <= 40;
                  stall_max <= 12;
               end
            endcase
         end
         func = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 3))
            0: value = {$urandom, $urandom};
            1: value = {$urandom, $urandom} >> $urandom_range(0, 63);
            2: begin
               // Around a power of ten, where the digit count changes.
               power = 64'd1;
               exponent = $urandom_range(0, 19);
               repeat (exponent) power = power * 64'd10;
               value = power + 64'($urandom_range(0, 4)) - 64'd2;
            end
            default: value = -({$urandom, $urandom} >> $urandom_range(1, 63));
         endcase
         send_number(func, value);
      end
   endtask

   // Hold off the output for a long stretch while numbers keep coming.
   task automatic test_output_stall(input int count);
      gap_max   = 0;
      burst_max = 64;
      burst_left = 0;
      stall_pct <= 10;
      stall_max <= 2;
      hold_token <= hold_token + 1;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) hold_token <= hold_token + 1;
         send_number(1'($urandom_range(0, 1)), {$urandom, $urandom});
      end
   endtask

   // Drive the output ready: long hold-off on request, else random stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
         hold_seen  <= hold_token;
      end else if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, stall_max);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each output transfer with the oldest owed character.
   always @(posedge clock) begin
      ascii_char_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR %0t: unexpected char %h last %b total %0d", $realtime,
                        rsp_character, rsp_last_char, rsp_total_chars);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_character !== want.character || rsp_last_char !== want.last_char ||
                rsp_total_chars !== want.total_chars) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR %0t: char %h/%h last %b/%b total %0d/%0d (exp/got)",
                           $realtime, want.character, rsp_character, want.last_char,
                           rsp_last_char, want.total_chars, rsp_total_chars);
            end
         end
      end
   end

   // Reset, run the tests in turn, drain and report.
   initial begin
      int waited;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_func  = FUNC_SIGNED;
      req_value = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_values();
      test_random_numbers(300);
      test_output_stall(36);
      req_valid <= 1'b0;

      waited = 0;
      while (pending_chars.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_chars.size() != 0)
         $display("ERROR: %0d expected characters never arrived", pending_chars.size());
      if (mismatch_count == 0 && pending_chars.size() == 0) begin
         $display("int64_to_decimal_ascii test passed");
      end else begin
         $display("int64_to_decimal_ascii test failed");
      end
      $finish;
   end

   // Watchdog on the whole run.
   initial begin
      #8ms;
      $display("int64_to_decimal_ascii test failed");
      $finish;
   end

endmodule
